// ----- src/bmhq_pkg.sv -----
`default_nettype none

package bmhq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int KEY_W         = 32;
    localparam int MODE_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 11;

    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EXTRACT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FINDMIN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [KEY_W-1:0] VAL_UNDERFLOW = -32'sd1;
    localparam logic signed [KEY_W-1:0] VAL_NONE      = 32'sd0;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [KEY_W-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [KEY_W-1:0]  value;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } out_item_t;

endpackage

`default_nettype wire

// ----- src/binary_max_heap_queue_unit.sv -----
`default_nettype none

// Clear, underflow, full and unused modes go straight to the result; peek reads the root;
// insert climbs one level per parent compare and writes the key where it stops; extract reads
// the root and the last entry, then sifts down one level per step; find min scans the leaf half.
// Throughput: one item at a time; s_ready returns the cycle after the result is loaded, and an
// untaken result holds the sequencer. Each sift or scan step makes one memory access a cycle.
// Reset (aresetn low, synchronous): heap empties, sequencer idles, no result pending.
module binary_max_heap_queue_unit #(
    parameter int DEPTH = bmhq_pkg::DEPTH_DEFAULT
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  bmhq_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output bmhq_pkg::out_item_t  m_data
);
    import bmhq_pkg::*;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CHW     = IDX_W + 2;
    localparam int CNT_EXT = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_EX_LAST = 4'd3;
    localparam logic [3:0] S_EX_LOAD = 4'd4;
    localparam logic [3:0] S_SD_RDL  = 4'd5;
    localparam logic [3:0] S_SD_RDR  = 4'd6;
    localparam logic [3:0] S_SD_CMP  = 4'd7;
    localparam logic [3:0] S_PK_GET  = 4'd8;
    localparam logic [3:0] S_FM_ACC  = 4'd9;
    localparam logic [3:0] S_FINISH  = 4'd10;

    logic [KEY_W-1:0] heap_mem [DEPTH];

    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] best_reg, best_next;
    logic                    best_left_reg, best_left_next;
    logic [CNT_W-1:0]        scan_reg, scan_next;
    logic                    first_reg, first_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic signed [KEY_W-1:0] res_value_reg, res_value_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;
    logic signed [KEY_W-1:0] rd_data_reg;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [KEY_W-1:0]        wr_data;

    logic [CHW-1:0]          child_l, child_r, count_wide;
    logic [IDX_W-1:0]        parent_idx;
    logic [CNT_EXT-1:0]      count_ext;
    logic                    out_free;

    assign child_l    = (CHW'(pos_reg) << 1) + CHW'(1);
    assign child_r    = child_l + CHW'(1);
    assign count_wide = CHW'(count_reg);
    assign parent_idx = IDX_W'((pos_reg - IDX_W'(1)) >> 1);
    assign count_ext  = CNT_EXT'(count_reg);
    assign out_free   = !out_valid_reg || m_ready;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        best_next       = best_reg;
        best_left_next  = best_left_reg;
        scan_next       = scan_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_data_next   = out_data_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = key_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_status_next = ST_OK;
                    res_value_next  = VAL_NONE;
                    state_next      = S_FINISH;
                    unique case (s_data.mode) inside
                        MODE_INSERT: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                pos_next   = IDX_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                                key_next   = s_data.key;
                                state_next = S_INS_RD;
                            end
                        end
                        MODE_EXTRACT, MODE_PEEK, MODE_FINDMIN: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                                res_value_next  = VAL_UNDERFLOW;
                            end else if (s_data.mode == MODE_FINDMIN) begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(count_reg >> 1);
                                scan_next  = (count_reg >> 1) + CNT_W'(1);
                                first_next = 1'b1;
                                state_next = S_FM_ACC;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = (s_data.mode == MODE_EXTRACT) ?
                                             S_EX_LAST : S_PK_GET;
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = parent_idx;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                wr_en = 1'b1;
                if (rd_data_reg < key_reg) begin
                    // pull the parent down into the hole, climb one level
                    wr_data    = rd_data_reg;
                    pos_next   = parent_idx;
                    state_next = S_INS_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_EX_LAST: begin
                res_value_next = rd_data_reg;
                rd_en          = 1'b1;
                rd_addr        = IDX_W'(count_reg - CNT_W'(1));
                state_next     = S_EX_LOAD;
            end
            S_EX_LOAD: begin
                key_next   = rd_data_reg;
                count_next = count_reg - CNT_W'(1);
                pos_next   = '0;
                state_next = S_SD_RDL;
            end
            S_SD_RDL: begin
                if (child_l >= count_wide) begin
                    wr_en      = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(child_l);
                    state_next = S_SD_RDR;
                end
            end
            S_SD_RDR: begin
                if (child_r < count_wide) begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(child_r);
                end
                if (key_reg < rd_data_reg) begin
                    best_next      = rd_data_reg;
                    best_left_next = 1'b1;
                end else begin
                    best_next      = key_reg;
                    best_left_next = 1'b0;
                end
                state_next = S_SD_CMP;
            end
            S_SD_CMP: begin
                wr_en = 1'b1;
                if (child_r < count_wide && best_reg < rd_data_reg) begin
                    wr_data    = rd_data_reg;
                    pos_next   = IDX_W'(child_r);
                    state_next = S_SD_RDL;
                end else if (best_left_reg) begin
                    wr_data    = best_reg;
                    pos_next   = IDX_W'(child_l);
                    state_next = S_SD_RDL;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_PK_GET: begin
                res_value_next = rd_data_reg;
                state_next     = S_FINISH;
            end
            S_FM_ACC: begin
                if (first_reg || rd_data_reg < res_value_reg) begin
                    res_value_next = rd_data_reg;
                end
                first_next = 1'b0;
                if (scan_reg < count_reg) begin
                    rd_en     = 1'b1;
                    rd_addr   = IDX_W'(scan_reg);
                    scan_next = scan_reg + CNT_W'(1);
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    out_data_next.status      = res_status_reg;
                    out_data_next.value       = res_value_reg;
                    out_data_next.entry_count = count_ext[ENTRY_COUNT_W-1:0];
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= heap_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        best_reg       <= best_next;
        best_left_reg  <= best_left_next;
        scan_reg       <= scan_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_data_reg   <= out_data_next;
    end

endmodule

`default_nettype wire
